// ===== design/unix_ms_to_calendar_date_assert.svh =====
// Assertion macros for the unix_ms_to_calendar_date checker.
// Used by the checker file only.
`ifndef UNIX_MS_TO_CALENDAR_DATE_ASSERT_SVH
`define UNIX_MS_TO_CALENDAR_DATE_ASSERT_SVH
// implication checked on every clock, off in reset
`define UMC_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication
`define UMC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== design/umc_pkg.sv =====
// Package for the Unix-ms to calendar date converter.
// Constants and shared types; no dependencies.
package umc_pkg;
  localparam int unsigned TS_W = 42;
  localparam logic [41:0] LIMIT_MS = 42'd4102444800000;
  localparam logic [11:0] EPOCH_YEAR = 12'd1970;

  // each divisor split as 2^k * odd part; reciprocals are floor(2^n / odd)
  localparam logic [16:0] DAY_ODD   = 17'd84375;   // 86400000 = 2^10 * 84375
  localparam logic [15:0] DAY_RCP   = 16'd50903;   // 2^32
  localparam logic [14:0] HOUR_ODD  = 15'd28125;   // 3600000 = 2^7 * 28125
  localparam logic [5:0]  HOUR_RCP  = 6'd37;       // 2^20
  localparam logic [10:0] MIN_ODD   = 11'd1875;    // 60000 = 2^5 * 1875
  localparam logic [6:0]  MIN_RCP   = 7'd69;       // 2^17
  localparam logic [6:0]  SEC_ODD   = 7'd125;      // 1000 = 2^3 * 125
  localparam logic [6:0]  SEC_RCP   = 7'd65;       // 2^13
  localparam logic [10:0] QUAD_DAYS = 11'd1461;    // days in four years
  localparam logic [5:0]  QUAD_RCP  = 6'd44;       // 2^16

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        oor;
  } date_t;

  // cumulative days before month m (m = 0..12)
  function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
    logic [8:0] v;
    case (m)
      4'd0: v = 9'd0;    4'd1: v = 9'd31;   4'd2: v = 9'd59;   4'd3: v = 9'd90;
      4'd4: v = 9'd120;  4'd5: v = 9'd151;  4'd6: v = 9'd181;  4'd7: v = 9'd212;
      4'd8: v = 9'd243;  4'd9: v = 9'd273;  4'd10: v = 9'd304; 4'd11: v = 9'd334;
      default: v = 9'd365;
    endcase
    if (leap && m >= 4'd2) v = v + 9'd1;
    return v;
  endfunction
endpackage

// ===== design/umc_engine.sv =====
// Eight-stage conversion pipeline: reciprocal divides with one correction step,
// four-year blocks for the year, parallel compares for the month. Depends on umc_pkg.
module umc_engine import umc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [TS_W-1:0] ts,
  output logic            res_valid,
  output date_t           res
);
  logic [8:1]  vld;

  logic [41:0] s1_ts;
  logic        s1_oor;
  logic [47:0] s1_prod;

  logic [41:0] s2_ts;
  logic [15:0] s2_qe;
  logic        s2_oor;
  logic [32:0] s2_mul, s2_rd;
  logic        s2_hi;
  logic [17:0] s2_rr;

  logic [15:0] s3_days;
  logic [26:0] s3_ms;
  logic        s3_oor;
  logic [21:0] s3_bp;
  logic [25:0] s3_hp;

  logic [15:0] s4_days;
  logic [5:0]  s4_qb, s4_qh;
  logic [26:0] s4_ms;
  logic        s4_oor;
  logic [15:0] s4_bm, s4_e0, s4_ec;
  logic        s4_bhi;
  logic [19:0] s4_hm, s4_r2;
  logic        s4_hhi;
  logic [15:0] s4_r2c;

  logic [5:0]  s5_b;
  logic [10:0] s5_e;
  logic [4:0]  s5_hour;
  logic [21:0] s5_msh;
  logic        s5_oor;
  logic [1:0]  s5_yoff;
  logic [8:0]  s5_doy;
  logic [23:0] s5_mp;

  logic [11:0] s6_year;
  logic [8:0]  s6_doy;
  logic        s6_leap;
  logic [4:0]  s6_hour;
  logic [21:0] s6_msh;
  logic [6:0]  s6_qm;
  logic        s6_oor;
  logic [3:0]  s6_mon;
  logic [16:0] s6_mm, s6_r3;
  logic        s6_mhi;
  logic [11:0] s6_r3c;

  logic [11:0] s7_year;
  logic [8:0]  s7_doy;
  logic        s7_leap;
  logic [3:0]  s7_mon;
  logic [4:0]  s7_hour;
  logic [5:0]  s7_min;
  logic [15:0] s7_msm;
  logic        s7_oor;
  logic [19:0] s7_sp;

  logic [11:0] s8_year;
  logic [3:0]  s8_mon;
  logic [4:0]  s8_day;
  logic [4:0]  s8_hour;
  logic [5:0]  s8_min;
  logic [12:0] s8_sx;
  logic [6:0]  s8_qs;
  logic        s8_oor;
  logic [12:0] s8_sm, s8_r4;
  logic        s8_shi;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[7:1], in_valid};
  end

  // stage 1: day estimate from ts / 2^10
  assign s1_prod = {16'd0, s1_ts[41:10]} * {32'd0, DAY_RCP};

  // stage 2: estimate is low by at most one
  assign s2_mul = {17'd0, s2_qe} * {16'd0, DAY_ODD};
  assign s2_rd  = {1'b0, s2_ts[41:10]} - s2_mul;
  assign s2_hi  = s2_rd[17:0] >= {1'b0, DAY_ODD};
  assign s2_rr  = s2_hi ? s2_rd[17:0] - {1'b0, DAY_ODD} : s2_rd[17:0];

  // stage 3: four-year block and hour estimates
  assign s3_bp = {6'd0, s3_days} * {16'd0, QUAD_RCP};
  assign s3_hp = {6'd0, s3_ms[26:7]} * {20'd0, HOUR_RCP};

  // stage 4: corrections
  assign s4_bm  = {10'd0, s4_qb} * {5'd0, QUAD_DAYS};
  assign s4_e0  = s4_days - s4_bm;
  assign s4_bhi = s4_e0 >= {5'd0, QUAD_DAYS};
  assign s4_ec  = s4_bhi ? s4_e0 - {5'd0, QUAD_DAYS} : s4_e0;
  assign s4_hm  = {14'd0, s4_qh} * {5'd0, HOUR_ODD};
  assign s4_r2  = s4_ms[26:7] - s4_hm;
  assign s4_hhi = s4_r2[15:0] >= {1'b0, HOUR_ODD};
  assign s4_r2c = s4_hhi ? s4_r2[15:0] - {1'b0, HOUR_ODD} : s4_r2[15:0];

  // stage 5: year inside the block (1970 + 4b, 365, 365, 366, 365)
  always_comb begin
    if (s5_e < 11'd365) begin
      s5_yoff = 2'd0;
      s5_doy  = 9'(s5_e);
    end else if (s5_e < 11'd730) begin
      s5_yoff = 2'd1;
      s5_doy  = 9'(s5_e - 11'd365);
    end else if (s5_e < 11'd1096) begin
      s5_yoff = 2'd2;
      s5_doy  = 9'(s5_e - 11'd730);
    end else begin
      s5_yoff = 2'd3;
      s5_doy  = 9'(s5_e - 11'd1096);
    end
  end
  assign s5_mp = {7'd0, s5_msh[21:5]} * {17'd0, MIN_RCP};

  // stage 6: month by compare against the cumulative table
  always_comb begin
    s6_mon = 4'd1;
    for (int k = 1; k < 12; k++)
      if (cum_days(4'(k), s6_leap) <= s6_doy) s6_mon = 4'(k + 1);
  end
  assign s6_mm  = {10'd0, s6_qm} * {6'd0, MIN_ODD};
  assign s6_r3  = s6_msh[21:5] - s6_mm;
  assign s6_mhi = s6_r3[11:0] >= {1'b0, MIN_ODD};
  assign s6_r3c = s6_mhi ? s6_r3[11:0] - {1'b0, MIN_ODD} : s6_r3[11:0];

  // stage 7: second estimate
  assign s7_sp = {7'd0, s7_msm[15:3]} * {13'd0, SEC_RCP};

  // stage 8: second correction, out-of-range zeroing of year, month and day
  assign s8_sm  = {6'd0, s8_qs} * {6'd0, SEC_ODD};
  assign s8_r4  = s8_sx - s8_sm;
  assign s8_shi = s8_r4[7:0] >= {1'b0, SEC_ODD};

  always_comb begin
    res.oor    = s8_oor;
    res.year   = s8_oor ? 12'd0 : s8_year;
    res.month  = s8_oor ? 4'd0 : s8_mon;
    res.day    = s8_oor ? 5'd0 : s8_day;
    res.hour   = s8_hour;
    res.minute = s8_min;
    res.second = 6'(s8_qs + {6'd0, s8_shi});
  end
  assign res_valid = vld[8];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ts   <= ts;
      s1_oor  <= ts >= LIMIT_MS;

      s2_ts   <= s1_ts;
      s2_qe   <= s1_prod[47:32];
      s2_oor  <= s1_oor;

      s3_days <= s2_qe + {15'd0, s2_hi};
      s3_ms   <= {s2_rr[16:0], s2_ts[9:0]};
      s3_oor  <= s2_oor;

      s4_days <= s3_days;
      s4_qb   <= s3_bp[21:16];
      s4_ms   <= s3_ms;
      s4_qh   <= s3_hp[25:20];
      s4_oor  <= s3_oor;

      s5_b    <= s4_qb + {5'd0, s4_bhi};
      s5_e    <= s4_ec[10:0];
      s5_hour <= 5'(s4_qh + {5'd0, s4_hhi});
      s5_msh  <= {s4_r2c[14:0], s4_ms[6:0]};
      s5_oor  <= s4_oor;

      s6_year <= EPOCH_YEAR + {4'd0, s5_b, 2'd0} + {10'd0, s5_yoff};
      s6_doy  <= s5_doy;
      s6_leap <= s5_yoff == 2'd2;
      s6_hour <= s5_hour;
      s6_msh  <= s5_msh;
      s6_qm   <= s5_mp[23:17];
      s6_oor  <= s5_oor;

      s7_year <= s6_year;
      s7_doy  <= s6_doy;
      s7_leap <= s6_leap;
      s7_mon  <= s6_mon;
      s7_hour <= s6_hour;
      s7_min  <= 6'(s6_qm + {6'd0, s6_mhi});
      s7_msm  <= {s6_r3c[10:0], s6_msh[4:0]};
      s7_oor  <= s6_oor;

      s8_year <= s7_year;
      s8_mon  <= s7_mon;
      s8_day  <= 5'(s7_doy - cum_days(s7_mon - 4'd1, s7_leap) + 9'd1);
      s8_hour <= s7_hour;
      s8_min  <= s7_min;
      s8_sx   <= s7_msm[15:3];
      s8_qs   <= s7_sp[19:13];
      s8_oor  <= s7_oor;
    end
  end
endmodule

// ===== design/unix_ms_to_calendar_date.sv =====
// Eight pipeline stages, the last feeding the output register. Throughput
// one word per cycle while out_ready stays high; a stalled output word
// freezes the whole pipeline and drops in_ready. Reset (rst, synchronous)
// clears the valid bits.
module unix_ms_to_calendar_date import umc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [TS_W-1:0] timestamp_ms,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [11:0]     year,
  output logic [3:0]      month,
  output logic [4:0]      day,
  output logic [4:0]      hour,
  output logic [5:0]      minute,
  output logic [5:0]      second,
  output logic            out_of_range
);
  logic adv, res_valid;
  date_t res, hold;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  umc_engine u_eng (.clk, .rst, .adv, .in_valid, .ts(timestamp_ms), .res_valid, .res);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= res_valid;
  end

  always_ff @(posedge clk) if (adv) hold <= res;

  assign year = hold.year;
  assign month = hold.month;
  assign day = hold.day;
  assign hour = hold.hour;
  assign minute = hold.minute;
  assign second = hold.second;
  assign out_of_range = hold.oor;
endmodule

// ===== design/umc_checker.sv =====
// Port-level checker for unix_ms_to_calendar_date, with its bind.
// Uses the assertion macro header.
`include "unix_ms_to_calendar_date_assert.svh"
module umc_checker (
  input logic clk, rst, in_ready, out_valid, out_ready,
  input logic [3:0] month, input logic [4:0] day, input logic out_of_range
);
  `UMC_ASSERT_IMP(a_stall, clk, rst, out_valid && !out_ready, !in_ready)
  `UMC_ASSERT_IMP(a_oor_zero, clk, rst, out_valid && out_of_range, month == 4'd0 && day == 5'd0)
  `UMC_ASSERT_IMP(a_month_ok, clk, rst, out_valid && !out_of_range, month != 4'd0 && month <= 4'd12)
  `UMC_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
  `UMC_ASSERT_NEXT(a_stable, clk, rst, out_valid && !out_ready, $stable(month) && $stable(day))
endmodule

bind unix_ms_to_calendar_date umc_checker u_chk (.clk, .rst, .in_ready,
  .out_valid, .out_ready, .month, .day, .out_of_range);

// ===== bench/tb_unix_ms_to_calendar_date.sv =====
// Testbench for unix_ms_to_calendar_date: directed and random timestamps,
// predicted dates checked in order by a small scoreboard. Depends on umc_pkg.
module tb_unix_ms_to_calendar_date;
  timeunit 1ns;
  timeprecision 1ps;
  import umc_pkg::*;

  typedef struct {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        oor;
  } cal_t;

  function automatic cal_t calc_date(logic [41:0] ts);
    cal_t r;
    longint unsigned secs, tod, days, yr, len;
    int unsigned m;
    int unsigned cum_c[13] = '{0,31,59,90,120,151,181,212,243,273,304,334,365};
    int unsigned cum_l[13] = '{0,31,60,91,121,152,182,213,244,274,305,335,366};
    int unsigned tab[13];
    secs = longint'(ts) / 1000;
    tod = secs % 86400;
    days = secs / 86400;
    r.hour = 5'(tod / 3600);
    r.minute = 6'((tod % 3600) / 60);
    r.second = 6'(tod % 60);
    r.year = 0; r.month = 0; r.day = 0; r.oor = 0;
    if (secs >= 64'd4102444800) begin
      r.oor = 1;
    end else begin
      yr = 1970;
      forever begin
        len = (yr % 4) ? 365 : 366;
        if (days >= len) begin
          days -= len; yr++;
        end else break;
      end
      if (yr % 4) tab = cum_c;
      else tab = cum_l;
      m = 1;
      while (m < 12 && tab[m] <= days) m++;
      r.year = 12'(yr);
      r.month = 4'(m);
      r.day = 5'(days - tab[m-1] + 1);
    end
    return r;
  endfunction

  class date_board;
    cal_t pending[$];
    int errors = 0;
    int checked = 0;
    function void note_stamp(logic [41:0] ts);
      pending.push_back(calc_date(ts));
    endfunction
    function void check_date(cal_t got);
      cal_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.year !== e.year) begin
        $error("year exp %0d got %0d", e.year, got.year); errors++;
      end
      if (got.month !== e.month) begin
        $error("month exp %0d got %0d", e.month, got.month); errors++;
      end
      if (got.day !== e.day) begin
        $error("day exp %0d got %0d", e.day, got.day); errors++;
      end
      if (got.hour !== e.hour) begin
        $error("hour exp %0d got %0d", e.hour, got.hour); errors++;
      end
      if (got.minute !== e.minute) begin
        $error("minute exp %0d got %0d", e.minute, got.minute); errors++;
      end
      if (got.second !== e.second) begin
        $error("second exp %0d got %0d", e.second, got.second); errors++;
      end
      if (got.oor !== e.oor) begin
        $error("out_of_range exp %0d got %0d", e.oor, got.oor); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic [41:0] timestamp_ms = '0;
  logic in_ready, out_valid, out_of_range;
  logic [11:0] year;
  logic [3:0] month;
  logic [4:0] day, hour;
  logic [5:0] minute, second;

  int send_idle = 0, recv_idle = 0;
  date_board board = new();

  unix_ms_to_calendar_date dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // receiver: random stall, check each taken word
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        board.check_date('{year, month, day, hour, minute, second, out_of_range});
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_stamp(logic [41:0] ts);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    timestamp_ms <= ts;
    board.note_stamp(ts);
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [41:0] rand_stamp();
    logic [41:0] v;
    case ($urandom_range(5))
      0: v = 42'({$urandom, $urandom});
      1: v = LIMIT_MS - 42'($urandom_range(5000));
      2: v = LIMIT_MS + 42'($urandom_range(5000));
      // near a year or day boundary
      3: v = 42'($urandom_range(129)) * 42'd31536000000
             + 42'($urandom_range(40)) * 42'd86400000 - 42'($urandom_range(2000));
      default: v = 42'({$urandom, $urandom}) % LIMIT_MS;
    endcase
    return v;
  endfunction

  task automatic run_phase(int sidle, int ridle, int n);
    send_idle = sidle;
    recv_idle = ridle;
    repeat (n) send_stamp(rand_stamp());
  endtask

  initial begin
    logic [41:0] directed[$] = '{
      42'd0, 42'd999, 42'd1000, 42'd86399999, 42'd86400000,
      42'd951782400000,                 // 2000-02-29
      42'd951868800000,                 // 2000-03-01
      42'd68169600000,                  // 1972-02-29
      42'd94607999999,                  // 1972-12-30 end
      42'd4102444799999, LIMIT_MS, LIMIT_MS + 42'd1,
      {42{1'b1}}, 42'h2AAAAAAAAAA, 42'h15555555555,
      42'd1700000000123, 42'd31535999999, 42'd31536000000};
    repeat (10) @(posedge clk);
    rst <= 0;
    send_idle = 0;
    recv_idle = 30;
    foreach (directed[i]) send_stamp(directed[i]);
    run_phase(7, 72, 540);
    run_phase(72, 7, 540);
    run_phase(0, 0, 540);
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("checked %0d dates: epoch, leap days, 2100 limit, random spans", board.checked);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #30ms;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== unix_ms_to_calendar_date.f =====
+incdir+design
design/umc_pkg.sv
design/umc_engine.sv
design/unix_ms_to_calendar_date.sv
design/umc_checker.sv
bench/tb_unix_ms_to_calendar_date.sv
